// ----- rtl/core/srt_pkg.sv -----
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types, constants and helpers for the signed radix to text unit.
// ----------------------------------------------------------------------------
package srt_pkg;

    localparam int MAX_BASE    = 16;
    localparam int DIGIT_W     = $clog2(MAX_BASE);
    localparam int VALUE_W     = 32;
    localparam int BASE_W      = 5;
    localparam int CHAR_W      = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int PTR_W       = $clog2(VALUE_W);

    localparam logic [CFG_INDEX_W-1:0] REG_BASE_LENGTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHABET_LOW  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHABET_HIGH = 2'd2;

    localparam logic [BASE_W-1:0]     BASE_LENGTH_RESET   = 5'd10;
    localparam logic [CFG_DATA_W-1:0] ALPHABET_LOW_RESET  = 64'd3978425819141910832;
    localparam logic [CFG_DATA_W-1:0] ALPHABET_HIGH_RESET = 64'd14648;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_SIGN,
        ST_EMIT
    } srt_state_t;

    // Result of one pass of the shared divider.
    typedef struct packed {
        logic                 done;
        logic [VALUE_W-1:0]   quotient;
        logic [DIGIT_W-1:0]   remainder;
    } srt_div_result_t;

    function automatic logic [CHAR_W-1:0] digit_char(
        input logic [CFG_DATA_W-1:0] alpha_low,
        input logic [CFG_DATA_W-1:0] alpha_high,
        input logic [DIGIT_W-1:0]    idx
    );
        logic [CFG_DATA_W-1:0] word;
        word = idx[DIGIT_W-1] ? alpha_high : alpha_low;
        return word[idx[DIGIT_W-2:0]*CHAR_W +: CHAR_W];
    endfunction

endpackage

// ----- rtl/core/srt_divider.sv -----
// ----------------------------------------------------------------------------
// srt_divider
// Restoring divider, one quotient bit per cycle, for a 32-bit magnitude by
// the configured radix. A result is flagged for one cycle when done.
// ----------------------------------------------------------------------------
module srt_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [srt_pkg::VALUE_W-1:0]   dividend,
    input  logic [srt_pkg::BASE_W-1:0]    divisor,
    output srt_pkg::srt_div_result_t      result
);
    import srt_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [PTR_W-1:0]     cnt_reg, cnt_next;
    logic [VALUE_W-1:0]   q_reg, q_next;
    logic [DIGIT_W-1:0]   r_reg, r_next;
    logic [BASE_W-1:0]    d_reg, d_next;
    logic [DIGIT_W:0]     trial;
    logic                 fits;

    // The running remainder stays below the divisor, so one extra bit suffices.
    assign trial = {r_reg, q_reg[VALUE_W-1]};
    assign fits  = trial >= d_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end else if (busy_reg) begin
            q_next   = {q_reg[VALUE_W-2:0], fits};
            r_next   = fits ? DIGIT_W'(trial - d_reg) : trial[DIGIT_W-1:0];
            cnt_next = PTR_W'(cnt_reg + 1'b1);
            if (cnt_reg == PTR_W'(VALUE_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign result.done      = done_reg;
    assign result.quotient  = q_reg;
    assign result.remainder = r_reg;

endmodule

// ----- rtl/core/signed_radix_to_text_unit.sv -----
// ----------------------------------------------------------------------------
// signed_radix_to_text_unit
// Writes a signed 32-bit value as text in a configurable radix, one
// character per result item, most significant digit first.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  s_       in         s_valid / s_ready     s_value (signed 32)
//  m_       out        m_valid / m_ready     m_character (8), m_final_char
//  cfg_     in         cfg_valid / cfg_ready cfg_index (2), cfg_data (64)
//
//  An item first checks the alphabet entry by entry, then runs the bit-serial
//  divider once per digit, then sends its characters, leading sign first.
//  Reset is synchronous and active low; the configuration returns to decimal.
//  A stalled result item holds the sequencer in the sign or digit state; a
//  new item is taken as soon as the last character sits in the output stage.
// ----------------------------------------------------------------------------
module signed_radix_to_text_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [srt_pkg::VALUE_W-1:0] s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [srt_pkg::CHAR_W-1:0]        m_character,
    output logic                              m_final_char,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [srt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [srt_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import srt_pkg::*;

    srt_state_t            state_reg, state_next;
    logic [BASE_W-1:0]     base_length_reg;
    logic [CFG_DATA_W-1:0] alphabet_low_reg, alphabet_high_reg;
    logic                  neg_reg;
    logic [VALUE_W-1:0]    mag_reg, mag_next;
    logic [DIGIT_W-1:0]    chk_idx_reg, chk_idx_next;
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [DIGIT_W-1:0]    digits_reg [VALUE_W];
    logic                  m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]     m_character_reg, m_character_next;
    logic                  m_final_char_reg, m_final_char_next;

    logic                  accept;
    logic                  out_free;
    logic                  div_start;
    logic                  digit_write;
    logic                  base_ok;
    logic [DIGIT_W-1:0]    last_idx;
    logic [CHAR_W-1:0]     chk_char;
    logic                  chk_bad;
    srt_div_result_t       div_res;

    // The divider loads the magnitude as it will be after this edge, so a
    // fresh quotient feeds the next digit straight away.
    srt_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mag_next),
        .divisor  (base_length_reg),
        .result   (div_res)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign base_ok  = (base_length_reg >= BASE_W'(2)) && (base_length_reg <= BASE_W'(MAX_BASE));
    assign last_idx = DIGIT_W'(base_length_reg - 1'b1);
    assign chk_char = digit_char(alphabet_low_reg, alphabet_high_reg, chk_idx_reg);

    // The current entry is checked against NUL, plus and minus and compared with every later used entry at once.
    always_comb begin
        chk_bad = (chk_char == CHAR_NUL) || (chk_char == CHAR_PLUS) || (chk_char == CHAR_MINUS);
        for (int j = 0; j < MAX_BASE; j++) begin
            if ((DIGIT_W'(j) > chk_idx_reg) && (BASE_W'(j) < base_length_reg) &&
                (digit_char(alphabet_low_reg, alphabet_high_reg, DIGIT_W'(j)) == chk_char)) begin
                chk_bad = 1'b1;
            end
        end
    end

    always_comb begin
        state_next        = state_reg;
        mag_next          = mag_reg;
        chk_idx_next      = chk_idx_reg;
        wr_ptr_next       = wr_ptr_reg;
        rd_ptr_next       = rd_ptr_reg;
        div_start         = 1'b0;
        digit_write       = 1'b0;
        m_valid_next      = m_valid_reg && !m_ready;
        m_character_next  = m_character_reg;
        m_final_char_next = m_final_char_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    mag_next     = s_value[VALUE_W-1] ? VALUE_W'(0) - VALUE_W'(s_value)
                                                      : VALUE_W'(s_value);
                    chk_idx_next = '0;
                    wr_ptr_next  = '0;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!base_ok || chk_bad) begin
                    state_next = ST_IDLE;
                end else if (chk_idx_reg == last_idx) begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end else begin
                    chk_idx_next = DIGIT_W'(chk_idx_reg + 1'b1);
                end
            end
            ST_DIVIDE: begin
                if (div_res.done) begin
                    digit_write = 1'b1;
                    mag_next    = div_res.quotient;
                    if ((div_res.quotient != '0) && (wr_ptr_reg != PTR_W'(VALUE_W - 1))) begin
                        wr_ptr_next = PTR_W'(wr_ptr_reg + 1'b1);
                        div_start   = 1'b1;
                    end else begin
                        rd_ptr_next = wr_ptr_reg;
                        state_next  = neg_reg ? ST_SIGN : ST_EMIT;
                    end
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_character_next  = CHAR_MINUS;
                    m_final_char_next = 1'b0;
                    state_next        = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_character_next  = digit_char(alphabet_low_reg, alphabet_high_reg,
                                                   digits_reg[rd_ptr_reg]);
                    m_final_char_next = (rd_ptr_reg == '0);
                    if (rd_ptr_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        rd_ptr_next = PTR_W'(rd_ptr_reg - 1'b1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_length_reg   <= BASE_LENGTH_RESET;
            alphabet_low_reg  <= ALPHABET_LOW_RESET;
            alphabet_high_reg <= ALPHABET_HIGH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_BASE_LENGTH:   base_length_reg   <= cfg_data[BASE_W-1:0];
                REG_ALPHABET_LOW:  alphabet_low_reg  <= cfg_data;
                REG_ALPHABET_HIGH: alphabet_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            neg_reg <= s_value[VALUE_W-1];
        end
        if (digit_write) begin
            digits_reg[wr_ptr_reg] <= div_res.remainder;
        end
        mag_reg          <= mag_next;
        chk_idx_reg      <= chk_idx_next;
        wr_ptr_reg       <= wr_ptr_next;
        rd_ptr_reg       <= rd_ptr_next;
        m_character_reg  <= m_character_next;
        m_final_char_reg <= m_final_char_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_character  = m_character_reg;
    assign m_final_char = m_final_char_reg;

    a_div_only_when_dividing: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside the divide state");

    a_accept_starts_check: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_CHECK))
        else $error("accepted item did not start the alphabet check");

    a_last_char_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free && rd_ptr_reg == '0)
        |=> (state_reg == ST_IDLE && m_valid_reg && m_final_char_reg))
        else $error("last character did not close the item");

    a_bad_alphabet_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK && !base_ok) |=> (state_reg == ST_IDLE && !div_res.done))
        else $error("invalid radix did not abandon the item");

endmodule
